@@ rtl/lmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and constants of the LED matrix row scan refresh controller.
// ----------------------------------------------------------------------------
package lmrs_pkg;

  localparam int ADDR_W   = 10;
  localparam int OFFSET_W = 10;
  localparam int LEN_W    = 11;
  localparam int APB_W    = 32;
  localparam int PADDR_W  = 3;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_SCROLL = 2'd2;

  localparam logic [0:0] REG_ACTIVE_LENGTH = 1'b0;

  localparam logic [LEN_W-1:0] LEN_RESET  = 11'd32;
  localparam int               MIN_LENGTH = 8;
  localparam int               ROWS       = 8;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        bits;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic [7:0] row_select;
    logic       latch;
  } result_t;

endpackage

@@ rtl/lmrs_fifo.sv @@
// ----------------------------------------------------------------------------
// lmrs_fifo
// Small synchronous queue with first-word fall-through output.
// ----------------------------------------------------------------------------
module lmrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/lmrs_front.sv @@
// ----------------------------------------------------------------------------
// lmrs_front
// Accepts input items, drops those that have no effect and queues the rest.
// ----------------------------------------------------------------------------
module lmrs_front
  import lmrs_pkg::*;
#(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic              push,
  output logic              full,
  input  logic [1:0]        cmd,
  input  logic [ADDR_W-1:0] address,
  input  logic [7:0]        column_bits,
  input  logic              ready,
  input  logic              queue_full,
  output logic              queue_push,
  output cmd_t              queue_data
);

  logic accept;
  logic useful;

  assign full   = queue_full || !ready;
  assign accept = push && !full;

  always_comb begin
    case (cmd)
      CMD_WRITE:  useful = (32'(address) < BUFFER_DEPTH);
      CMD_TICK:   useful = 1'b1;
      CMD_SCROLL: useful = 1'b1;
      default:    useful = 1'b0;
    endcase
  end

  assign queue_push      = accept && useful;
  assign queue_data.kind = cmd;
  assign queue_data.addr = address;
  assign queue_data.bits = column_bits;

endmodule

@@ rtl/lmrs_back.sv @@
// ----------------------------------------------------------------------------
// lmrs_back
// Executes queued commands: buffer writes, scrolling and refresh ticks,
// and clears the frame buffer after reset.
// ----------------------------------------------------------------------------
module lmrs_back
  import lmrs_pkg::*;
#(
  parameter int MATRICES     = 4,
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] active_length,
  input  logic             cmd_empty,
  input  cmd_t             cmd_data,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output result_t          res_data,
  output logic             ready
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int LW  = $clog2(BUFFER_DEPTH + 1);
  localparam int SW  = (LW > LEN_W) ? LW : LEN_W;
  localparam int MCW = (MATRICES > 1) ? $clog2(MATRICES) : 1;
  localparam int BW  = $clog2(OFFSET_W);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_NORM  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_WB    = 3'd5;

  logic [7:0]          mem [BUFFER_DEPTH];
  logic [2:0]          state;
  logic [AW-1:0]       clr_addr;
  logic [OFFSET_W-1:0] offset;
  logic [2:0]          row;
  logic [BW-1:0]       bit_idx;
  logic [LW-1:0]       rem;
  logic [LW-1:0]       idx;
  logic [MCW-1:0]      mcnt;
  logic [7:0]          rd_data;

  logic [LW-1:0]       len;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;
  logic                rd_en;
  logic [SW-1:0]       scroll_next;
  logic [LW:0]         rem_shift;
  logic [LW:0]         base;
  logic [LW:0]         step;
  logic                last;

  always_comb begin
    if (active_length < LEN_W'(MIN_LENGTH)) begin
      len = LW'(MIN_LENGTH);
    end else if (32'(active_length) > BUFFER_DEPTH) begin
      len = LW'(BUFFER_DEPTH);
    end else begin
      len = LW'(active_length);
    end
  end

  assign ready       = (state != ST_CLEAR);
  assign cmd_pop     = (state == ST_IDLE) && !cmd_empty;
  assign rd_en       = (state == ST_READ) && !res_full;
  assign last        = (mcnt == MCW'(MATRICES - 1));
  assign scroll_next = SW'(offset) + SW'(1);
  assign rem_shift   = {rem, offset[bit_idx]};
  assign base        = {1'b0, rem} + (LW + 1)'(row);
  assign step        = {1'b0, idx} + (LW + 1)'(ROWS);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (cmd_pop && cmd_data.kind == CMD_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(cmd_data.addr);
      mem_wdata = cmd_data.bits;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  assign res_push            = (state == ST_WB);
  assign res_data.pixel_byte = rd_data;
  assign res_data.row_select = 8'b1 << row;
  assign res_data.latch      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      offset   <= '0;
      row      <= '0;
      bit_idx  <= '0;
      rem      <= '0;
      idx      <= '0;
      mcnt     <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(BUFFER_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_pop) begin
            case (cmd_data.kind)
              CMD_SCROLL: begin
                if (scroll_next >= SW'(len)) begin
                  offset <= '0;
                end else begin
                  offset <= scroll_next[OFFSET_W-1:0];
                end
              end
              CMD_TICK: begin
                rem     <= '0;
                bit_idx <= BW'(OFFSET_W - 1);
                state   <= ST_MOD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MOD: begin
          if (rem_shift >= {1'b0, len}) begin
            rem <= LW'(rem_shift - {1'b0, len});
          end else begin
            rem <= LW'(rem_shift);
          end
          bit_idx <= bit_idx - BW'(1);
          if (bit_idx == '0) begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (base >= {1'b0, len}) begin
            idx <= LW'(base - {1'b0, len});
          end else begin
            idx <= LW'(base);
          end
          mcnt  <= '0;
          state <= ST_READ;
        end
        ST_READ: begin
          if (!res_full) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (last) begin
            row   <= row + 3'd1;
            state <= ST_IDLE;
          end else begin
            if (step >= {1'b0, len}) begin
              idx <= LW'(step - {1'b0, len});
            end else begin
              idx <= LW'(step);
            end
            mcnt  <= mcnt + MCW'(1);
            state <= ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/led_matrix_row_scan_refresh.sv @@
// ----------------------------------------------------------------------------
// led_matrix_row_scan_refresh
// Row scan refresh controller for a chain of 8x8 LED matrices with a
// scrolling column frame buffer.
// ----------------------------------------------------------------------------
// Writes and scrolls are executed in the command unit after queueing.
// A refresh tick computes a ten-step remainder of the scroll offset, then
// does one frame buffer read per matrix on a single port.
// Reset is synchronous; afterwards the buffer is cleared, and full stays
// high while it clears.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_refresh
  import lmrs_pkg::*;
#(
  parameter int MATRICES     = 4,
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd,
  input  logic [ADDR_W-1:0]  address,
  input  logic [7:0]         column_bits,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         pixel_byte,
  output logic [7:0]         row_select,
  output logic               latch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  logic [LEN_W-1:0] active_length;
  logic             ready;
  logic             cmd_push;
  cmd_t             cmd_in;
  logic             cmd_full;
  logic             cmd_pop;
  cmd_t             cmd_out;
  logic             cmd_empty;
  logic             res_push;
  result_t          res_in;
  logic             res_full;
  result_t          res_out;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_ACTIVE_LENGTH);
  assign prdata  = reg_sel ? APB_W'(active_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      active_length <= pwdata[LEN_W-1:0];
    end
  end

  lmrs_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .address    (address),
    .column_bits(column_bits),
    .ready      (ready),
    .queue_full (cmd_full),
    .queue_push (cmd_push),
    .queue_data (cmd_in)
  );

  lmrs_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(4)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_data(cmd_in),
    .rd_en  (cmd_pop),
    .rd_data(cmd_out),
    .full   (cmd_full),
    .empty  (cmd_empty)
  );

  lmrs_back #(
    .MATRICES    (MATRICES),
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .active_length(active_length),
    .cmd_empty    (cmd_empty),
    .cmd_data     (cmd_out),
    .cmd_pop      (cmd_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_data     (res_in),
    .ready        (ready)
  );

  lmrs_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(4)
  ) u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_in),
    .rd_en  (pop),
    .rd_data(res_out),
    .full   (res_full),
    .empty  (empty)
  );

  assign pixel_byte = res_out.pixel_byte;
  assign row_select = res_out.row_select;
  assign latch      = res_out.latch;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    !ready |-> full)
    else $error("input accepted during buffer clear");

  a_result_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  a_row_onehot: assert property (@(posedge clk) disable iff (rst)
    !empty |-> $onehot(row_select))
    else $error("row select not one-hot");

endmodule
